FILE: src/lppc_pkg.sv
// lppc_pkg: shared types and constants for the l4 protocol packet counter
// holds header offsets, ethertype and protocol codes, and the parser result struct
// no dependencies
package lppc_pkg;

  // byte position counter, saturating
  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  // frame length arithmetic is one bit wider than the position
  localparam int unsigned LEN_W = POS_W + 1;

  // capture positions of the ethertype and the encapsulated type
  localparam logic [POS_W-1:0] POS_TYPE_HI  = 7'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO  = 7'd13;
  localparam logic [POS_W-1:0] POS_INNER_HI = 7'd16;
  localparam logic [POS_W-1:0] POS_INNER_LO = 7'd17;

  // l3 start and minimum lengths
  localparam logic [LEN_W-1:0] L3_UNTAGGED  = 8'd14;
  localparam logic [LEN_W-1:0] L3_TAGGED    = 8'd18;
  localparam logic [LEN_W-1:0] IPV4_HDR_LEN = 8'd20;
  localparam logic [LEN_W-1:0] IPV6_HDR_LEN = 8'd40;
  localparam logic [LEN_W-1:0] IPV4_PROTO_OFS = 8'd9;
  localparam logic [LEN_W-1:0] IPV6_NEXT_OFS  = 8'd6;

  // ethertypes
  localparam logic [15:0] TYPE_VLAN_Q  = 16'h8100;
  localparam logic [15:0] TYPE_VLAN_AD = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] TYPE_IPV6    = 16'h86DD;

  // l4 protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // enable mask bit positions
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned MASK_TOTAL = 0;
  localparam int unsigned MASK_ICMP  = 1;
  localparam int unsigned MASK_TCP   = 2;
  localparam int unsigned MASK_UDP   = 3;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

  // width of the count ports
  localparam int unsigned OUT_COUNT_W = 64;

  // per-frame classification handed from parser to counters
  typedef struct packed {
    logic       verdict;
    logic [7:0] l4_protocol;
    logic       was_ip;
    logic       hit_icmp;
    logic       hit_tcp;
    logic       hit_udp;
  } lppc_cls_t;

endpackage

FILE: src/l4_protocol_packet_counter.sv
// l4_protocol_packet_counter: top level of the ethernet l4 protocol counter
// instantiates lppc_parser and lppc_counters, uses lppc_pkg
//
// Frame bytes enter one beat per cycle while in_stall is low, destination MAC
// first, with in_last_byte on the final beat; a new beat may follow every cycle.
// The EtherType is read at bytes 12..13, one 802.1Q/802.1ad tag is skipped, and
// the IPv4 protocol or IPv6 next-header byte is captured. One result beat per
// frame leaves once its last byte is accepted, via the parse register and then
// the counter/result register. Frames shorter than the Ethernet (or tagged) header give
// verdict 1 and count nothing. Counters are COUNT_WIDTH bits, wrap, are zero-extended
// onto the 64-bit ports, and are never cleared by a mask write. cfg_wr_data bit 0
// enables the total count, bit 1 ICMP, bit 2 TCP, bit 3 UDP; write it only while idle.
module l4_protocol_packet_counter #(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic [7:0]  out_l4_protocol,
  output logic        out_was_ip,
  output logic [63:0] out_total_count,
  output logic [63:0] out_udp_count,
  output logic [63:0] out_tcp_count,
  output logic [63:0] out_icmp_count
);
  import lppc_pkg::*;

  lppc_cls_t cls;
  logic      cls_valid;
  logic      cls_ready;

  // header parse and frame classification
  lppc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_packet_byte(in_packet_byte),
    .in_last_byte  (in_last_byte),
    .cls_o         (cls),
    .cls_valid_o   (cls_valid),
    .cls_ready_i   (cls_ready)
  );

  // counters and result register
  lppc_counters #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counters (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cls_i          (cls),
    .cls_valid_i    (cls_valid),
    .cls_ready_o    (cls_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_l4_protocol(out_l4_protocol),
    .out_was_ip     (out_was_ip),
    .out_total_count(out_total_count),
    .out_udp_count  (out_udp_count),
    .out_tcp_count  (out_tcp_count),
    .out_icmp_count (out_icmp_count)
  );

endmodule

FILE: src/lppc_parser.sv
// lppc_parser: per-byte header parse and end-of-frame classification
// registers one classification per frame for the counter stage
// depends on lppc_pkg
module lppc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_packet_byte,
  input  logic               in_last_byte,
  output lppc_pkg::lppc_cls_t cls_o,
  output logic               cls_valid_o,
  input  logic               cls_ready_i
);
  import lppc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      ether_type_r, ether_type_nxt;
  logic [15:0]      inner_type_r, inner_type_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic             cls_valid_r, cls_valid_nxt;
  lppc_cls_t        cls_r, cls_nxt;

  logic             accept;
  logic             is_vlan;
  logic [15:0]      eff_type;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] l3;
  logic [LEN_W-1:0] need;
  logic             is_v4;
  logic             is_v6;
  logic [7:0]       proto_final;

  // a beat is held back only while a finished frame waits downstream
  assign in_stall = cls_valid_r & ~cls_ready_i;
  assign accept   = in_valid & ~in_stall;

  // header field capture with the current beat folded in
  always_comb begin
    ether_type_nxt = ether_type_r;
    inner_type_nxt = inner_type_r;
    if (pos_r == POS_TYPE_HI) begin
      ether_type_nxt = {in_packet_byte, 8'h00};
    end else if (pos_r == POS_TYPE_LO) begin
      ether_type_nxt = {ether_type_r[15:8], in_packet_byte};
    end else if (pos_r == POS_INNER_HI) begin
      inner_type_nxt = {in_packet_byte, 8'h00};
    end else if (pos_r == POS_INNER_LO) begin
      inner_type_nxt = {inner_type_r[15:8], in_packet_byte};
    end
  end

  // l3 layout from the captured types
  assign is_vlan  = (ether_type_nxt == TYPE_VLAN_Q) || (ether_type_nxt == TYPE_VLAN_AD);
  assign eff_type = is_vlan ? inner_type_nxt : ether_type_nxt;
  assign l3       = is_vlan ? L3_TAGGED : L3_UNTAGGED;
  assign is_v4    = (eff_type == TYPE_IPV4);
  assign is_v6    = (eff_type == TYPE_IPV6);
  assign pos_ext  = {1'b0, pos_r};
  assign len      = pos_ext + LEN_W'(1);
  assign need     = l3 + (is_v4 ? IPV4_HDR_LEN : IPV6_HDR_LEN);

  // protocol byte capture
  always_comb begin
    proto_nxt = proto_r;
    if (pos_ext >= L3_UNTAGGED) begin
      if (is_v4 && (pos_ext == l3 + IPV4_PROTO_OFS)) begin
        proto_nxt = in_packet_byte;
      end
      if (is_v6 && (pos_ext == l3 + IPV6_NEXT_OFS)) begin
        proto_nxt = in_packet_byte;
      end
    end
  end

  // end-of-frame classification
  always_comb begin
    cls_nxt     = '0;
    proto_final = (len >= need) ? proto_nxt : 8'h00;
    if ((len < L3_UNTAGGED) || (is_vlan && (len < L3_TAGGED))) begin
      cls_nxt.verdict = 1'b1;
    end else if (is_v4 || is_v6) begin
      cls_nxt.was_ip      = 1'b1;
      cls_nxt.l4_protocol = proto_final;
      cls_nxt.hit_udp     = (proto_final == PROTO_UDP);
      cls_nxt.hit_tcp     = (proto_final == PROTO_TCP);
      cls_nxt.hit_icmp    = (proto_final == PROTO_ICMP);
    end
  end

  // position counter saturates, everything clears after the last beat
  always_comb begin
    pos_nxt = pos_r;
    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // output slot: refills when empty or draining
  always_comb begin
    cls_valid_nxt = cls_valid_r;
    if (~cls_valid_r || cls_ready_i) begin
      cls_valid_nxt = accept & in_last_byte;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      ether_type_r <= '0;
      inner_type_r <= '0;
      proto_r      <= '0;
      cls_valid_r  <= 1'b0;
    end else begin
      cls_valid_r <= cls_valid_nxt;
      if (accept) begin
        if (in_last_byte) begin
          pos_r        <= '0;
          ether_type_r <= '0;
          inner_type_r <= '0;
          proto_r      <= '0;
        end else begin
          pos_r        <= pos_nxt;
          ether_type_r <= ether_type_nxt;
          inner_type_r <= inner_type_nxt;
          proto_r      <= proto_nxt;
        end
      end
    end
  end

  // classification payload
  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_o       = cls_r;
  assign cls_valid_o = cls_valid_r;

endmodule

FILE: src/lppc_counters.sv
// lppc_counters: enable mask, wrapping protocol counters and result register
// takes one classification per frame from the parser
// depends on lppc_pkg
module lppc_counters #(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  lppc_pkg::lppc_cls_t cls_i,
  input  logic                cls_valid_i,
  output logic                cls_ready_o,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_verdict,
  output logic [7:0]          out_l4_protocol,
  output logic                out_was_ip,
  output logic [63:0]         out_total_count,
  output logic [63:0]         out_udp_count,
  output logic [63:0]         out_tcp_count,
  output logic [63:0]         out_icmp_count
);
  import lppc_pkg::*;

  logic [MASK_W-1:0]      mask_r;
  logic [COUNT_WIDTH-1:0] total_r, udp_r, tcp_r, icmp_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   verdict_r;
  logic [7:0]             proto_r;
  logic                   was_ip_r;
  logic                   take;

  // result slot frees when empty or taken this cycle
  assign cls_ready_o = ~out_valid_r | ~out_stall;
  assign take        = cls_valid_i & cls_ready_o;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cls_ready_o) begin
      out_valid_nxt = cls_valid_i;
    end
  end

  // enable mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // counters, each bumped only when its mask bit is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      udp_r   <= '0;
      tcp_r   <= '0;
      icmp_r  <= '0;
    end else if (take) begin
      if (cls_i.was_ip && mask_r[MASK_TOTAL]) begin
        total_r <= total_r + COUNT_WIDTH'(1);
      end
      if (cls_i.hit_udp && mask_r[MASK_UDP]) begin
        udp_r <= udp_r + COUNT_WIDTH'(1);
      end
      if (cls_i.hit_tcp && mask_r[MASK_TCP]) begin
        tcp_r <= tcp_r + COUNT_WIDTH'(1);
      end
      if (cls_i.hit_icmp && mask_r[MASK_ICMP]) begin
        icmp_r <= icmp_r + COUNT_WIDTH'(1);
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      verdict_r <= cls_i.verdict;
      proto_r   <= cls_i.l4_protocol;
      was_ip_r  <= cls_i.was_ip;
    end
  end

  // counters only move when a new result enters, so they double as the output
  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_l4_protocol = proto_r;
  assign out_was_ip      = was_ip_r;
  assign out_total_count = OUT_COUNT_W'(total_r);
  assign out_udp_count   = OUT_COUNT_W'(udp_r);
  assign out_tcp_count   = OUT_COUNT_W'(tcp_r);
  assign out_icmp_count  = OUT_COUNT_W'(icmp_r);

endmodule

FILE: src/lppc_checker.sv
// lppc_checker: port-level assertions for the l4 protocol packet counter
// bound to l4_protocol_packet_counter, sees its ports only
module lppc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_verdict,
  input  logic [7:0]  out_l4_protocol,
  input  logic        out_was_ip,
  input  logic [63:0] out_total_count,
  input  logic [63:0] out_udp_count,
  input  logic [63:0] out_tcp_count,
  input  logic [63:0] out_icmp_count
);

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // a stalled result beat holds, counts included
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_count)
      && $stable(out_udp_count) && $stable(out_tcp_count)
      && $stable(out_icmp_count) && $stable(out_l4_protocol))
    else $error("stalled result beat changed");

  // an aborted frame carries no protocol and is not ip
  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict |-> out_l4_protocol == 8'h00 && !out_was_ip)
    else $error("aborted frame reports protocol or ip");

  // a protocol is only reported for an ip frame
  a_proto_ip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_l4_protocol != 8'h00) |-> out_was_ip)
    else $error("protocol reported for non-ip frame");

endmodule

bind l4_protocol_packet_counter lppc_checker u_lppc_checker (.*);

FILE: tb/l4_protocol_packet_counter_test.sv
// l4_protocol_packet_counter_test: self-checking testbench for the l4 protocol packet counter
// drives ethernet frames byte by byte and checks every result beat against a frame classifier
// depends on lppc_pkg and l4_protocol_packet_counter
`timescale 1ns / 1ps

module l4_protocol_packet_counter_test;
  import lppc_pkg::*;

  localparam int unsigned RANDOM_BEATS = 540;
  localparam int unsigned PHASE_BEATS  = 135;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        verdict;
    logic [7:0]  l4_protocol;
    logic        was_ip;
    logic [63:0] total;
    logic [63:0] udp;
    logic [63:0] tcp;
    logic [63:0] icmp;
  } frame_result_t;

  // one directed frame: shape, and the verdict fields where they are obvious
  typedef struct {
    int unsigned len;
    logic [15:0] outer;
    logic [15:0] inner;
    logic [7:0]  proto;
    bit          typed;
    logic        verdict;
    logic [7:0]  l4_protocol;
    logic        was_ip;
  } frame_row_t;

  localparam int unsigned N_ROWS = 22;

  frame_row_t directed_frames [N_ROWS] = '{
    '{1,   TYPE_IPV4,    16'h0000,  8'd0,       1, 1'b1, 8'd0,       1'b0},
    '{2,   TYPE_IPV4,    16'h0000,  8'd0,       1, 1'b1, 8'd0,       1'b0},
    '{13,  TYPE_IPV4,    16'h0000,  8'd0,       1, 1'b1, 8'd0,       1'b0},
    '{14,  TYPE_IPV4,    16'h0000,  8'd0,       1, 1'b0, 8'd0,       1'b1},
    '{14,  16'h1234,     16'h0000,  8'd0,       1, 1'b0, 8'd0,       1'b0},
    '{14,  TYPE_VLAN_Q,  TYPE_IPV4, 8'd0,       1, 1'b1, 8'd0,       1'b0},
    '{17,  TYPE_VLAN_Q,  TYPE_IPV4, 8'd0,       1, 1'b1, 8'd0,       1'b0},
    '{18,  TYPE_VLAN_AD, TYPE_IPV6, 8'd0,       1, 1'b0, 8'd0,       1'b1},
    '{33,  TYPE_IPV4,    16'h0000,  PROTO_UDP,  1, 1'b0, 8'd0,       1'b1},
    '{34,  TYPE_IPV4,    16'h0000,  PROTO_UDP,  1, 1'b0, PROTO_UDP,  1'b1},
    '{34,  TYPE_IPV4,    16'h0000,  PROTO_TCP,  1, 1'b0, PROTO_TCP,  1'b1},
    '{34,  TYPE_IPV4,    16'h0000,  PROTO_ICMP, 1, 1'b0, PROTO_ICMP, 1'b1},
    '{34,  TYPE_IPV4,    16'h0000,  8'd255,     1, 1'b0, 8'd255,     1'b1},
    '{34,  TYPE_IPV4,    16'h0000,  8'd0,       1, 1'b0, 8'd0,       1'b1},
    '{53,  TYPE_IPV6,    16'h0000,  PROTO_TCP,  1, 1'b0, 8'd0,       1'b1},
    '{54,  TYPE_IPV6,    16'h0000,  PROTO_TCP,  1, 1'b0, PROTO_TCP,  1'b1},
    '{60,  TYPE_IPV6,    16'h0000,  PROTO_UDP,  1, 1'b0, PROTO_UDP,  1'b1},
    '{38,  TYPE_VLAN_Q,  TYPE_IPV4, PROTO_UDP,  1, 1'b0, PROTO_UDP,  1'b1},
    '{58,  TYPE_VLAN_AD, TYPE_IPV6, PROTO_ICMP, 1, 1'b0, PROTO_ICMP, 1'b1},
    '{40,  TYPE_VLAN_Q,  16'h0806,  8'd0,       1, 1'b0, 8'd0,       1'b0},
    '{64,  16'hFFFF,     16'h0000,  8'd0,       1, 1'b0, 8'd0,       1'b0},
    '{200, TYPE_IPV4,    16'h0000,  PROTO_TCP,  1, 1'b0, PROTO_TCP,  1'b1}
  };

  // block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = 4'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_verdict;
  logic [7:0]  out_l4_protocol;
  logic        out_was_ip;
  logic [63:0] out_total_count;
  logic [63:0] out_udp_count;
  logic [63:0] out_tcp_count;
  logic [63:0] out_icmp_count;

  // classifier state
  logic [POS_W-1:0]  frame_pos;
  logic [15:0]       outer_type;
  logic [15:0]       inner_type;
  logic [7:0]        proto_seen;
  logic [63:0]       proto_counts [4];
  logic [MASK_W-1:0] enable_mask;

  frame_result_t pending_results [$];
  logic [7:0]    frame_bytes [$];
  bit            quiet = 1'b0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   random_beats = 0;

  l4_protocol_packet_counter #(
    .COUNT_WIDTH (64)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_packet_byte  (in_packet_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_l4_protocol (out_l4_protocol),
    .out_was_ip      (out_was_ip),
    .out_total_count (out_total_count),
    .out_udp_count   (out_udp_count),
    .out_tcp_count   (out_tcp_count),
    .out_icmp_count  (out_icmp_count)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("l4_protocol_packet_counter_test NOT OK");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 33);
  end

  function automatic void bump_count(int unsigned idx);
    if (enable_mask[idx])
      proto_counts[idx] = proto_counts[idx] + 64'd1;
  endfunction

  function automatic void clear_frame_state();
    frame_pos  = '0;
    outer_type = '0;
    inner_type = '0;
    proto_seen = '0;
  endfunction

  // classify one accepted beat; a result is produced on the last byte only
  task automatic classify_beat(input logic [7:0] b, input logic last,
                               output bit done, output frame_result_t res);
    logic [LEN_W-1:0] at;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] l3;
    logic [LEN_W-1:0] need;
    logic [15:0]      eff;
    logic             is_vlan;
    logic [7:0]       proto;
    done = 1'b0;
    res  = '0;
    at   = {1'b0, frame_pos};
    case (frame_pos)
      POS_TYPE_HI:  outer_type = {b, 8'h00};
      POS_TYPE_LO:  outer_type[7:0] = b;
      POS_INNER_HI: inner_type = {b, 8'h00};
      POS_INNER_LO: inner_type[7:0] = b;
      default: ;
    endcase
    is_vlan = (outer_type == TYPE_VLAN_Q) || (outer_type == TYPE_VLAN_AD);
    l3      = is_vlan ? L3_TAGGED : L3_UNTAGGED;
    eff     = is_vlan ? inner_type : outer_type;
    // protocol capture inside the l3 header
    if (at >= L3_UNTAGGED && at >= l3) begin
      if (eff == TYPE_IPV4 && at == l3 + IPV4_PROTO_OFS) proto_seen = b;
      if (eff == TYPE_IPV6 && at == l3 + IPV6_NEXT_OFS) proto_seen = b;
    end
    if (frame_pos != POS_MAX)
      frame_pos = frame_pos + 1'b1;
    if (!last)
      return;

    done = 1'b1;
    len  = at + 1'b1;
    if (len < L3_UNTAGGED || (is_vlan && len < L3_TAGGED)) begin
      res.verdict = 1'b1;
    end else if (eff == TYPE_IPV4 || eff == TYPE_IPV6) begin
      need  = l3 + ((eff == TYPE_IPV4) ? IPV4_HDR_LEN : IPV6_HDR_LEN);
      proto = (len >= need) ? proto_seen : 8'd0;
      res.was_ip      = 1'b1;
      res.l4_protocol = proto;
      if (proto == PROTO_UDP) bump_count(MASK_UDP);
      else if (proto == PROTO_TCP) bump_count(MASK_TCP);
      else if (proto == PROTO_ICMP) bump_count(MASK_ICMP);
      bump_count(MASK_TOTAL);
    end
    res.total = proto_counts[MASK_TOTAL];
    res.udp   = proto_counts[MASK_UDP];
    res.tcp   = proto_counts[MASK_TCP];
    res.icmp  = proto_counts[MASK_ICMP];
    clear_frame_state();
  endtask

  // drive one beat at the falling edge, with random idle cycles before it
  task automatic send_beat(input logic [7:0] b, input logic last,
                           output bit done, output frame_result_t res);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_packet_byte <= b;
    in_last_byte   <= last;
    do @(posedge clk); while (in_stall);
    classify_beat(b, last, done, res);
  endtask

  // lay out a frame: random filler with type, tag and protocol bytes placed
  task automatic build_frame(input int unsigned len, input logic [15:0] outer,
                             input logic [15:0] inner, input logic [7:0] proto);
    int unsigned l3;
    logic [15:0] eff;
    frame_bytes.delete();
    for (int unsigned i = 0; i < len; i++)
      frame_bytes.push_back(8'($urandom_range(255)));
    if (len > 12) frame_bytes[12] = outer[15:8];
    if (len > 13) frame_bytes[13] = outer[7:0];
    if (outer == TYPE_VLAN_Q || outer == TYPE_VLAN_AD) begin
      if (len > 16) frame_bytes[16] = inner[15:8];
      if (len > 17) frame_bytes[17] = inner[7:0];
      l3  = 18;
      eff = inner;
    end else begin
      l3  = 14;
      eff = outer;
    end
    if (eff == TYPE_IPV4 && len > l3 + 9) frame_bytes[l3 + 9] = proto;
    if (eff == TYPE_IPV6 && len > l3 + 6) frame_bytes[l3 + 6] = proto;
  endtask

  // send a whole frame and queue its expected result
  task automatic send_frame(input frame_row_t row);
    bit            done;
    frame_result_t res;
    build_frame(row.len, row.outer, row.inner, row.proto);
    foreach (frame_bytes[i]) begin
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1, done, res);
      if (done) begin
        if (row.typed) begin
          res.verdict     = row.verdict;
          res.l4_protocol = row.l4_protocol;
          res.was_ip      = row.was_ip;
        end
        pending_results.push_back(res);
      end
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    enable_mask = value;
  endtask

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // result beat checker
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, total %0h", $time, out_total_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", want.verdict, out_verdict);
        check_field("l4_protocol", want.l4_protocol, out_l4_protocol);
        check_field("was_ip", want.was_ip, out_was_ip);
        check_field("total_count", want.total, out_total_count);
        check_field("udp_count", want.udp, out_udp_count);
        check_field("tcp_count", want.tcp, out_tcp_count);
        check_field("icmp_count", want.icmp, out_icmp_count);
      end
    end
  end

  initial begin : stimulus
    frame_row_t  row;
    int unsigned phase;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned l3;
    int unsigned need;
    logic [15:0] eff;

    clear_frame_state();
    for (int i = 0; i < 4; i++) proto_counts[i] = '0;
    enable_mask = MASK_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset mask
    foreach (directed_frames[i]) send_frame(directed_frames[i]);
    drain();

    // random frames in phases, the mask rewritten while idle between them
    phase = 0;
    while (random_beats < RANDOM_BEATS) begin
      case (phase)
        0:       write_mask(4'h0);
        1:       write_mask(4'hF);
        2:       write_mask(4'hA);
        3:       write_mask(4'h5);
        default: write_mask(4'($urandom_range(15)));
      endcase
      quiet = (phase == 2);
      phase_start = random_beats;
      while (random_beats - phase_start < PHASE_BEATS && random_beats < RANDOM_BEATS) begin
        row   = '{0, 16'h0, 16'h0, 8'h0, 0, 1'b0, 8'h0, 1'b0};
        pick  = $urandom_range(99);
        if (pick < 75) begin
          // well-formed ip frame, sometimes truncated or very long
          if ($urandom_range(2) == 0) begin
            row.outer = $urandom_range(1) ? TYPE_VLAN_Q : TYPE_VLAN_AD;
            row.inner = $urandom_range(1) ? TYPE_IPV4 : TYPE_IPV6;
            l3  = 18;
            eff = row.inner;
          end else begin
            row.outer = $urandom_range(1) ? TYPE_IPV4 : TYPE_IPV6;
            l3  = 14;
            eff = row.outer;
          end
          case ($urandom_range(4))
            0:       row.proto = PROTO_UDP;
            1:       row.proto = PROTO_TCP;
            2:       row.proto = PROTO_ICMP;
            default: row.proto = 8'($urandom_range(255));
          endcase
          need = l3 + ((eff == TYPE_IPV4) ? 20 : 40);
          pick = $urandom_range(99);
          if (pick < 10)      row.len = $urandom_range(need - 1, l3);
          else if (pick < 14) row.len = $urandom_range(160, 100);
          else                row.len = need + $urandom_range(12);
        end else if (pick < 88) begin
          // other ethertypes
          row.outer = 16'($urandom_range(16'hFFFF));
          row.inner = 16'($urandom_range(16'hFFFF));
          row.len   = $urandom_range(60, 14);
        end else begin
          // short frame, header cut short when tagged or under 14 bytes
          row.outer = $urandom_range(1) ? TYPE_VLAN_Q : 16'($urandom_range(16'hFFFF));
          row.inner = TYPE_IPV4;
          row.len   = $urandom_range(17, 1);
        end
        send_frame(row);
        random_beats += row.len;
      end
      drain();
      phase++;
    end
    quiet = 1'b0;

    if (mismatch_count == 0) begin
      $display("l4_protocol_packet_counter_test OK");
    end else begin
      $display("l4_protocol_packet_counter_test NOT OK");
    end
    $finish;
  end

endmodule
